@@ hw/rtl/pis_pkg.sv @@
// Shared types, codes and saturation helper for the particle integrator step unit.
package pis_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_STEP      = 2'd0;
    localparam logic [1:0] OP_LOAD_POS  = 2'd1;
    localparam logic [1:0] OP_LOAD_PREV = 2'd2;
    localparam logic [1:0] OP_LOAD_VEL  = 2'd3;

    // Integration modes
    localparam logic [1:0] MODE_EXPLICIT = 2'd0;
    localparam logic [1:0] MODE_SEMI     = 2'd1;
    localparam logic [1:0] MODE_VERLET   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_MODE      = 2'd1;
    localparam logic [1:0] CFG_PINNED    = 2'd2;
    localparam logic [1:0] CFG_LIFETIME  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration reset values
    localparam logic [16:0] TIME_STEP_RST = 17'd655;
    localparam logic [15:0] LIFETIME_RST  = 16'd500;

    // Damping factor 0.3 in Q16.16, as a signed multiplier operand
    localparam logic signed [17:0] DAMP_Q = 18'sd19661;

    // Datapath widths
    localparam int MUL_A_W = 33;                  // signed operand (state or difference)
    localparam int MUL_B_W = 18;                  // signed operand (dt or damping)
    localparam int PROD_W  = MUL_A_W + MUL_B_W;   // full product
    localparam int SH_W    = PROD_W - 16;         // product after the Q16.16 shift
    localparam int SUM_W   = SH_W + 2;            // room for three terms

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               advanced;
        logic               saturated;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_F,
        ST_UPD_V,
        ST_MUL_P,
        ST_UPD_P,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MSEL_FORCE,
        MSEL_DIFF,
        MSEL_VEL
    } mul_sel_t;

    typedef struct packed {
        logic     capture;   // input transaction accepted this cycle
        logic     step_go;   // accepted transaction is a step that will run
        logic     diff_ld;   // latch pos - prev of the active axis
        logic     upd_v;     // form the new velocity of the active axis
        logic     damp_ld;   // latch the damping term of the active axis
        logic     upd_p;     // write back the active axis and rotate
        logic     out_load;  // load the result register
        mul_sel_t mul_sel;   // multiplier operand select
    } cmd_t;

    typedef struct packed {
        logic step_ok;   // offered transaction is a step that moves the particle
        logic out_free;  // result register can take a new result
    } status_t;

    // Clamp a wide sum to the signed 32-bit range; MSB of the result flags a clamp
    function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [32:0] r;
        if ((v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1)) begin
            r = {1'b0, v[31:0]};
        end else if (v[SUM_W-1]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/particle_integrator_step_unit.sv @@
// Top level of the particle integrator step unit.
//
// Holds one point particle (position, previous position, velocity as signed Q16.16
// three-vectors) and returns one result per input transaction with the position and
// velocity after it. A load transaction writes one vector and its result is registered
// in ST_FINISH once the result register is free. A step that moves the particle (not
// pinned, nonzero lifetime, known mode) runs the three axes one after the other through
// a single shared 33x18 multiplier, four steps per axis (force*dt, velocity update,
// damping product, position update), before ST_FINISH; any other step goes directly to
// ST_FINISH. The next transaction is accepted the cycle after the result is registered,
// so none is taken while one is in progress or a previous result still waits on m_ready.
// Configuration writes take effect at once and are meant to be issued while idle.
module particle_integrator_step_unit
    import pis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    cmd_t    cmd;
    status_t status;

    // Sequence the work
    pis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold state and do the arithmetic
    pis_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hw/rtl/pis_ctrl.sv @@
// Sequencing state machine of the particle integrator step unit.
module pis_ctrl
    import pis_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    // State and axis counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                axis_next = 2'd0;
                if (s_valid) begin
                    state_next = status.step_ok ? ST_MUL_F : ST_FINISH;
                end
            end
            ST_MUL_F: state_next = ST_UPD_V;
            ST_UPD_V: state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_UPD_P;
            ST_UPD_P: begin
                if (axis_reg == 2'd2) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL_F;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready  = 1'b0;
        cmd      = '0;
        cmd.mul_sel = MSEL_FORCE;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                cmd.step_go = s_valid && status.step_ok;
            end
            ST_MUL_F: begin
                cmd.diff_ld = 1'b1;
                cmd.mul_sel = MSEL_FORCE;
            end
            ST_UPD_V: begin
                cmd.upd_v   = 1'b1;
                cmd.mul_sel = MSEL_DIFF;
            end
            ST_MUL_P: begin
                cmd.damp_ld = 1'b1;
                cmd.mul_sel = MSEL_VEL;
            end
            ST_UPD_P: begin
                cmd.upd_p = 1'b1;
            end
            ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/pis_datapath.sv @@
// State vectors, configuration, shared multiplier and result register of the integrator.
module pis_datapath
    import pis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_t                   s_data,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    // Configuration
    logic [16:0] ts_reg;
    logic [1:0]  mode_reg;
    logic        pin_reg;
    logic [15:0] life_reg;

    // Particle state; entry 0 is the axis being worked on
    logic signed [31:0] pos_reg   [3];
    logic signed [31:0] prev_reg  [3];
    logic signed [31:0] vel_reg   [3];
    logic signed [31:0] force_reg [3];

    logic signed [MUL_A_W-1:0] diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SH_W-1:0]    damp_reg;
    logic signed [31:0]        newvel_reg;
    logic                      adv_reg;
    logic                      sat_reg;
    logic                      m_valid_reg;
    out_t                      out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SH_W-1:0]    prod_sh;
    logic signed [SUM_W-1:0]   vel_sum;
    logic signed [SUM_W-1:0]   pos_sum;
    logic [32:0]               vel_sat;
    logic [32:0]               pos_sat;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg   <= TIME_STEP_RST;
            mode_reg <= MODE_EXPLICIT;
            pin_reg  <= 1'b0;
            life_reg <= LIFETIME_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIME_STEP: ts_reg   <= cfg_wdata;
                CFG_MODE:      mode_reg <= cfg_wdata[1:0];
                CFG_PINNED:    pin_reg  <= cfg_wdata[0];
                CFG_LIFETIME:  life_reg <= cfg_wdata[15:0];
                default:       ts_reg   <= ts_reg;
            endcase
        end
    end

    // Decide whether an offered step moves the particle
    assign status.step_ok  = (s_data.operation == OP_STEP) && !pin_reg
                             && (life_reg != 16'd0)
                             && ((mode_reg == MODE_EXPLICIT) || (mode_reg == MODE_SEMI)
                                 || (mode_reg == MODE_VERLET));
    assign status.out_free = !m_valid_reg || m_ready;

    // Select multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            MSEL_FORCE: begin
                mul_a = MUL_A_W'(force_reg[0]);
                mul_b = signed'({1'b0, ts_reg});
            end
            MSEL_DIFF: begin
                mul_a = diff_reg;
                mul_b = DAMP_Q;
            end
            MSEL_VEL: begin
                mul_a = (mode_reg == MODE_EXPLICIT) ? MUL_A_W'(vel_reg[0])
                                                    : MUL_A_W'(newvel_reg);
                mul_b = signed'({1'b0, ts_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod_sh = prod_reg[PROD_W-1:16];

    // Form the new velocity and new position of the active axis
    assign vel_sum = SUM_W'(vel_reg[0]) + SUM_W'(prod_sh);
    assign pos_sum = SUM_W'(pos_reg[0]) + SUM_W'(damp_reg) + SUM_W'(prod_sh);
    assign vel_sat = sat32(vel_sum);
    assign pos_sat = sat32(pos_sum);

    // Multiply and hold intermediate terms
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (cmd.diff_ld) begin
            diff_reg <= MUL_A_W'(pos_reg[0]) - MUL_A_W'(prev_reg[0]);
        end
        if (cmd.upd_v) begin
            newvel_reg <= vel_sat[31:0];
        end
        if (cmd.damp_ld) begin
            damp_reg <= (mode_reg == MODE_VERLET) ? prod_sh : '0;
        end
        if (cmd.capture) begin
            force_reg[0] <= s_data.vec_x;
            force_reg[1] <= s_data.vec_y;
            force_reg[2] <= s_data.vec_z;
        end else if (cmd.upd_p) begin
            force_reg[0] <= force_reg[1];
            force_reg[1] <= force_reg[2];
            force_reg[2] <= force_reg[0];
        end
    end

    // Load or update the particle state, rotating axes after each update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
        end else if (cmd.capture) begin
            case (s_data.operation)
                OP_LOAD_POS: begin
                    pos_reg[0] <= s_data.vec_x;
                    pos_reg[1] <= s_data.vec_y;
                    pos_reg[2] <= s_data.vec_z;
                end
                OP_LOAD_PREV: begin
                    prev_reg[0] <= s_data.vec_x;
                    prev_reg[1] <= s_data.vec_y;
                    prev_reg[2] <= s_data.vec_z;
                end
                OP_LOAD_VEL: begin
                    vel_reg[0] <= s_data.vec_x;
                    vel_reg[1] <= s_data.vec_y;
                    vel_reg[2] <= s_data.vec_z;
                end
                default: pos_reg[0] <= pos_reg[0];
            endcase
        end else if (cmd.upd_p) begin
            pos_reg[0]  <= pos_reg[1];
            pos_reg[1]  <= pos_reg[2];
            pos_reg[2]  <= pos_sat[31:0];
            prev_reg[0] <= prev_reg[1];
            prev_reg[1] <= prev_reg[2];
            prev_reg[2] <= pos_reg[0];
            vel_reg[0]  <= vel_reg[1];
            vel_reg[1]  <= vel_reg[2];
            vel_reg[2]  <= newvel_reg;
        end
    end

    // Track step and clamp flags of the current transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adv_reg <= 1'b0;
            sat_reg <= 1'b0;
        end else if (cmd.capture) begin
            adv_reg <= cmd.step_go;
            sat_reg <= 1'b0;
        end else begin
            if (cmd.upd_v && vel_sat[32]) begin
                sat_reg <= 1'b1;
            end
            if (cmd.upd_p && pos_sat[32]) begin
                sat_reg <= 1'b1;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.pos_x     <= pos_reg[0];
            out_reg.pos_y     <= pos_reg[1];
            out_reg.pos_z     <= pos_reg[2];
            out_reg.vel_x     <= vel_reg[0];
            out_reg.vel_y     <= vel_reg[1];
            out_reg.vel_z     <= vel_reg[2];
            out_reg.advanced  <= adv_reg;
            out_reg.saturated <= sat_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
